// ----- rtl/srpd_pkg.sv -----
// Package for the sorted peer ring directory: table size, derived widths,
// request and result codes, and the hop count helper. No dependencies.
`default_nettype none

package srpd_pkg;

  localparam int MAX_PEERS = 16;
  localparam int IDX_W     = $clog2(MAX_PEERS);
  localparam int CNT_W     = $clog2(MAX_PEERS + 1);

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int VALUE_W = 7;

  typedef enum logic [1:0] {
    OP_JOIN    = 2'd0,
    OP_CHANGE  = 2'd1,
    OP_LEAVE   = 2'd2,
    OP_INVALID = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    K_DENIED = 3'd0,
    K_COUNT  = 3'd1,
    K_NB     = 3'd2,
    K_HOP    = 3'd3,
    K_STATUS = 3'd4,
    K_ACK    = 3'd5
  } kind_t;

  localparam logic [VALUE_W-1:0] STATUS_NONE = 7'd0;
  localparam logic [VALUE_W-1:0] STATUS_ONE  = 7'd1;
  localparam logic [VALUE_W-1:0] STATUS_TWO  = 7'd2;

  // One table entry as it moves between neighboring cells.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    logic              changed;
  } srpd_entry_t;

  // Per-cell command from the sequencer.
  typedef struct packed {
    logic load_req;
    logic take_left;
    logic take_right;
    logic set_flag;
    logic clr_flag;
  } srpd_cell_cmd_t;

  // Hop count: zero up to four peers, else (n-1)/2 - 1.
  function automatic logic [VALUE_W-1:0] hop_of(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] h;
    h = ((n - CNT_W'(1)) >> 1) - CNT_W'(1);
    if (n <= CNT_W'(4)) begin
      hop_of = '0;
    end else begin
      hop_of = VALUE_W'(h);
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/srpd_if.sv -----
// Valid/ready channel interfaces for the request and result transactions.
// Depends on srpd_pkg for the field widths.
`default_nettype none

interface srpd_req_if import srpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [ADDR_W-1:0] peer_addr;
  logic [PORT_W-1:0] peer_port;

  modport source(output valid, output opcode, output peer_addr, output peer_port,
                 input ready);
  modport sink(input valid, input opcode, input peer_addr, input peer_port,
               output ready);
endinterface

interface srpd_rsp_if import srpd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [VALUE_W-1:0] value;
  logic [ADDR_W-1:0]  nb_addr;
  logic [PORT_W-1:0]  nb_port;
  logic               last;

  modport source(output valid, output kind, output value, output nb_addr,
                 output nb_port, output last, input ready);
  modport sink(input valid, input kind, input value, input nb_addr,
               input nb_port, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/srpd_cell.sv -----
// One slot of the peer table: holds an entry, compares it with the request,
// and shifts from its left or right neighbor on insert and remove.
// Depends on srpd_pkg.
`default_nettype none

module srpd_cell import srpd_pkg::*; (
  input  wire logic              clk,
  input  wire srpd_cell_cmd_t    cmd,
  input  wire logic [ADDR_W-1:0] req_addr,
  input  wire logic [PORT_W-1:0] req_port,
  input  wire srpd_entry_t       left,
  input  wire srpd_entry_t       right,
  output srpd_entry_t            entry,
  output logic                   match,
  output logic                   greater
);

  srpd_entry_t slot;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      slot.addr    <= req_addr;
      slot.port    <= req_port;
      slot.changed <= 1'b0;
    end else if (cmd.take_left) begin
      slot <= left;
    end else if (cmd.take_right) begin
      slot <= right;
    end else if (cmd.set_flag) begin
      slot.changed <= 1'b1;
    end else if (cmd.clr_flag) begin
      slot.changed <= 1'b0;
    end
  end

  assign entry   = slot;
  assign match   = (slot.port == req_port) && (slot.addr == req_addr);
  assign greater = (req_port < slot.port);

endmodule

`default_nettype wire

// ----- rtl/sorted_peer_ring_directory_top.sv -----
// Top level of the sorted peer ring directory: the row of table cells and
// the request sequencer with its result register. Depends on srpd_pkg,
// srpd_if and srpd_cell.
`default_nettype none

// The directory keeps up to MAX_PEERS peers in a row of cells, sorted by
// ascending port, and treats the row as a ring. Requests are handled one at
// a time. A join walks accept, search, locate and insert, then issues its
// up to four results. How many results a change query gives depends on how
// many neighbors it reports. A leave ends in one acknowledgement and a
// denied join gives only its denial. The sequencer walks search, locate,
// update and, for a leave, shift before it issues results one per cycle,
// while the result channel does not stall, through a single result
// register. A stalled result channel holds the sequencer. An invalid opcode
// is taken and gives no result. Change queries and leaves for unknown peers
// also give no result. A new request is taken as soon as the final result
// of the previous one sits in the result register. Inserting and removing a
// peer is a single shift of the cell row, each cell taking its left or
// right neighbor.

module sorted_peer_ring_directory_top import srpd_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  srpd_req_if.sink  req,
  srpd_rsp_if.source rsp
);

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_FIND, S_UPDATE, S_SHIFT,
    S_DENY, S_HEAD, S_PREV, S_NEXT, S_HOP, S_ACK
  } state_t;

  state_t                state;
  opcode_t               op;
  logic [ADDR_W-1:0]     raddr;
  logic [PORT_W-1:0]     rport;
  logic [MAX_PEERS-1:0]  hit;
  logic [MAX_PEERS-1:0]  mvec;
  logic [IDX_W-1:0]      idx;
  logic                  is_match;
  logic                  was_changed;
  logic [CNT_W-1:0]      count;

  // Result register.
  logic                  ovalid;
  kind_t                 okind;
  logic [VALUE_W-1:0]    ovalue;
  logic [ADDR_W-1:0]     oaddr;
  logic [PORT_W-1:0]     oport;
  logic                  olast;

  srpd_entry_t           ent [MAX_PEERS];
  srpd_cell_cmd_t        cmd [MAX_PEERS];
  logic [MAX_PEERS-1:0]  mt;
  logic [MAX_PEERS-1:0]  gt;
  logic [MAX_PEERS-1:0]  live;

  // The cell row. Cell zero has nothing on its left and the top cell
  // nothing on its right. A removal leaves the freed top slot holding its
  // old entry. Slots at or above the peer count are never read.
  for (genvar j = 0; j < MAX_PEERS; j++) begin : g_cell
    srpd_entry_t left_in;
    srpd_entry_t right_in;

    if (j == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = ent[j-1];
    end
    if (j == MAX_PEERS - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = ent[j+1];
    end

    assign live[j] = (CNT_W'(j) < count);

    srpd_cell u_cell (
      .clk      (clk),
      .cmd      (cmd[j]),
      .req_addr (raddr),
      .req_port (rport),
      .left     (left_in),
      .right    (right_in),
      .entry    (ent[j]),
      .match    (mt[j]),
      .greater  (gt[j])
    );
  end

  // Ring neighbors of the located entry, over the current peer count.
  logic [IDX_W-1:0] prev;
  logic [IDX_W-1:0] next;
  logic [CNT_W-1:0] idx_plus;

  assign idx_plus = CNT_W'(idx) + CNT_W'(1);
  assign prev     = (idx == '0) ? IDX_W'(count - CNT_W'(1)) : idx - IDX_W'(1);
  assign next     = (idx_plus >= count) ? '0 : IDX_W'(idx_plus);

  // One read port into the row, steered by the sequencer.
  logic [IDX_W-1:0] rd_idx;
  srpd_entry_t      rd_ent;

  always_comb begin
    case (state)
      S_PREV:  rd_idx = prev;
      S_NEXT:  rd_idx = next;
      default: rd_idx = idx;
    endcase
  end

  assign rd_ent = ent[rd_idx];

  // A join stops at a matching peer or at the first larger port; the other
  // requests look for an exact match only.
  logic [MAX_PEERS-1:0] hit_now;
  assign hit_now = (op == OP_JOIN) ? (live & (mt | gt)) : (live & mt);

  // Lowest set bit of the registered hit vector.
  logic [IDX_W-1:0] enc;
  logic             found;

  always_comb begin
    enc = '0;
    for (int j = MAX_PEERS - 1; j >= 0; j--) begin
      if (hit[j]) begin
        enc = IDX_W'(j);
      end
    end
  end

  assign found = |hit;

  // Cell commands.
  always_comb begin
    for (int j = 0; j < MAX_PEERS; j++) begin
      cmd[j] = '0;
      case (state)
        S_UPDATE: begin
          case (op)
            OP_JOIN: begin
              if (is_match) begin
                cmd[j].clr_flag = (IDX_W'(j) == idx);
              end else begin
                cmd[j].load_req  = (IDX_W'(j) == idx);
                cmd[j].take_left = (CNT_W'(j) > CNT_W'(idx)) && (CNT_W'(j) <= count);
              end
            end
            OP_CHANGE: cmd[j].clr_flag = (IDX_W'(j) == idx);
            OP_LEAVE:  cmd[j].set_flag = (IDX_W'(j) == prev) || (IDX_W'(j) == next);
            default:   cmd[j] = '0;
          endcase
        end
        S_SHIFT: begin
          cmd[j].take_right = (CNT_W'(j) >= CNT_W'(idx))
                              && ((CNT_W'(j) + CNT_W'(1)) < count);
        end
        S_PREV: cmd[j].set_flag = (op == OP_JOIN) && (IDX_W'(j) == prev);
        S_NEXT: cmd[j].set_flag = (op == OP_JOIN) && (IDX_W'(j) == next);
        default: cmd[j] = '0;
      endcase
    end
  end

  // Result selection for the issuing states.
  logic               e_go;
  kind_t              e_kind;
  logic [VALUE_W-1:0] e_value;
  logic [ADDR_W-1:0]  e_addr;
  logic [PORT_W-1:0]  e_port;
  logic               e_last;
  state_t             e_next;
  logic               out_free;

  assign out_free = !ovalid || rsp.ready;

  always_comb begin
    e_go    = 1'b0;
    e_kind  = K_DENIED;
    e_value = '0;
    e_addr  = '0;
    e_port  = '0;
    e_last  = 1'b0;
    e_next  = S_IDLE;
    case (state)
      S_DENY: begin
        e_go   = 1'b1;
        e_last = 1'b1;
      end
      S_HEAD: begin
        e_go = 1'b1;
        if (op == OP_JOIN) begin
          e_kind  = K_COUNT;
          e_value = (count <= CNT_W'(2)) ? VALUE_W'(count - CNT_W'(1)) : STATUS_TWO;
          if (count == CNT_W'(1)) begin
            e_next = S_HOP;
          end else if (count == CNT_W'(2)) begin
            e_next = S_NEXT;
          end else begin
            e_next = S_PREV;
          end
        end else begin
          e_kind = K_STATUS;
          if (was_changed) begin
            e_value = (count > CNT_W'(2)) ? STATUS_TWO : STATUS_ONE;
            e_next  = S_PREV;
          end else begin
            e_value = STATUS_NONE;
            e_next  = S_HOP;
          end
        end
      end
      S_PREV: begin
        e_go   = 1'b1;
        e_kind = K_NB;
        e_addr = rd_ent.addr;
        e_port = rd_ent.port;
        e_next = (count > CNT_W'(2)) ? S_NEXT : S_HOP;
      end
      S_NEXT: begin
        e_go   = 1'b1;
        e_kind = K_NB;
        e_addr = rd_ent.addr;
        e_port = rd_ent.port;
        e_next = S_HOP;
      end
      S_HOP: begin
        e_go    = 1'b1;
        e_kind  = K_HOP;
        e_value = hop_of(count);
        e_last  = 1'b1;
      end
      S_ACK: begin
        e_go   = 1'b1;
        e_kind = K_ACK;
        e_last = 1'b1;
      end
      default: e_go = 1'b0;
    endcase
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      ovalid <= 1'b0;
    end else begin
      if (e_go && out_free) begin
        ovalid <= 1'b1;
      end else if (rsp.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op    <= opcode_t'(req.opcode);
            raddr <= req.peer_addr;
            rport <= req.peer_port;
            if (opcode_t'(req.opcode) == OP_INVALID) begin
              state <= S_IDLE;
            end else if ((opcode_t'(req.opcode) == OP_JOIN)
                         && (count == CNT_W'(MAX_PEERS))) begin
              state <= S_DENY;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          hit   <= hit_now;
          mvec  <= live & mt;
          state <= S_FIND;
        end
        S_FIND: begin
          if (!found && (op != OP_JOIN)) begin
            state <= S_IDLE;
          end else begin
            idx      <= found ? enc : IDX_W'(count);
            is_match <= found && mvec[enc];
            state    <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          case (op)
            OP_JOIN: begin
              if (!is_match) begin
                count <= count + CNT_W'(1);
              end
              state <= S_HEAD;
            end
            OP_CHANGE: begin
              was_changed <= rd_ent.changed;
              state       <= S_HEAD;
            end
            OP_LEAVE: state <= S_SHIFT;
            default:  state <= S_IDLE;
          endcase
        end
        S_SHIFT: begin
          count <= count - CNT_W'(1);
          state <= S_ACK;
        end
        default: begin
          if (e_go && out_free) begin
            okind  <= e_kind;
            ovalue <= e_value;
            oaddr  <= e_addr;
            oport  <= e_port;
            olast  <= e_last;
            state  <= e_next;
          end
        end
      endcase
    end
  end

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = ovalid;
  assign rsp.kind    = okind;
  assign rsp.value   = ovalue;
  assign rsp.nb_addr = oaddr;
  assign rsp.nb_port = oport;
  assign rsp.last    = olast;

endmodule

`default_nettype wire

// ----- rtl/srpd_checker.sv -----
// Port-level checks for the sorted peer ring directory, bound to the top
// level. Depends on srpd_pkg and sorted_peer_ring_directory_top.
`default_nettype none

module srpd_port_checks import srpd_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire logic [1:0]         req_opcode,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic [2:0]         rsp_kind,
  input wire logic [VALUE_W-1:0] rsp_value,
  input wire logic [ADDR_W-1:0]  rsp_nb_addr,
  input wire logic [PORT_W-1:0]  rsp_nb_port,
  input wire logic               rsp_last
);

  // A stalled result holds its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_value)
      && $stable(rsp_nb_addr) && $stable(rsp_nb_port) && $stable(rsp_last))
    else $error("result changed while stalled");

  // A real request occupies the block for at least the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_opcode != OP_INVALID) |=> !req_ready)
    else $error("request taken while another is in progress");

  // Closing results end a transaction sequence, opening ones never do.
  a_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_last == ((rsp_kind == K_DENIED) || (rsp_kind == K_HOP)
                                || (rsp_kind == K_ACK))))
    else $error("last flag does not match result kind");

  // Only neighbor results carry an address and port.
  a_nb_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_kind != K_NB) |-> (rsp_nb_addr == '0) && (rsp_nb_port == '0))
    else $error("neighbor fields set on a non-neighbor result");

endmodule

bind sorted_peer_ring_directory_top srpd_port_checks u_srpd_port_checks (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_opcode  (req.opcode),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_kind    (rsp.kind),
  .rsp_value   (rsp.value),
  .rsp_nb_addr (rsp.nb_addr),
  .rsp_nb_port (rsp.nb_port),
  .rsp_last    (rsp.last)
);

`default_nettype wire
